[rtl/sao_pkg.sv]
// Shared constants and types of the straight-alpha source-over blender.
`timescale 1ns / 1ps

package sao_pkg;

  localparam int CH_W      = 8;   // width of one colour or alpha channel
  localparam int PROD_W    = 16;  // channel times alpha
  localparam int COV_W     = 16;  // combined coverage, at most 255*255
  localparam int NUM_W     = 25;  // colour numerator
  localparam int QBITS     = 8;   // quotient bits, one per divider stage
  localparam int LANES     = 3;   // red, green, blue
  localparam int DIV_FIRST = 3;   // first divider stage
  localparam int DEPTH     = DIV_FIRST + QBITS;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;
  // Reciprocal of 255 for coverage values below 65536: floor(x/255) = ((x+1)*257) >> 16.
  localparam logic [8:0] RECIP_255 = 9'd257;

  typedef struct packed {
    logic [DEPTH-1:0] en;     // stage loads at this edge
    logic [DEPTH-1:0] valid;  // stage holds a pixel
  } pipe_ctrl_t;

endpackage

[rtl/sao_if.sv]
// Pixel channel interfaces: the source/destination pair in, the blended pixel out.
`timescale 1ns / 1ps

interface sao_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (output valid, src_red, src_green, src_blue, src_alpha,
                  dst_red, dst_green, dst_blue, dst_alpha, input ready);
  modport sink   (input valid, src_red, src_green, src_blue, src_alpha,
                  dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

interface sao_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

[rtl/sao_ctrl.sv]
// Valid bits and per-stage load enables of the blending pipeline.
`timescale 1ns / 1ps

module sao_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output sao_pkg::pipe_ctrl_t ctrl
);

  localparam int DEPTH = sao_pkg::DEPTH;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] en;

  // A stage may load when the output is taken or some stage at or after it is empty.
  for (genvar s = 0; s < DEPTH; s++) begin : g_en
    assign en[s] = out_ready | ~(&valid[DEPTH-1:s]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int s = 1; s < DEPTH; s++) begin
        if (en[s]) begin
          valid[s] <= valid[s-1];
        end
      end
    end
  end

  assign ctrl.en    = en;
  assign ctrl.valid = valid;

endmodule

[rtl/sao_lane.sv]
// One colour lane: products, numerator and a bit-per-stage restoring divider.
`timescale 1ns / 1ps

module sao_lane (
  input  logic                                clk,
  input  sao_pkg::pipe_ctrl_t                 ctrl,
  input  logic [sao_pkg::CH_W-1:0]            sc,
  input  logic [sao_pkg::CH_W-1:0]            dc,
  input  logic [sao_pkg::CH_W-1:0]            sa0,
  input  logic [sao_pkg::CH_W-1:0]            da0,
  input  logic [sao_pkg::CH_W-1:0]            inv1,
  input  logic [sao_pkg::COV_W-1:0]           cov_line [sao_pkg::QBITS],
  input  logic                                bypass,
  output logic [sao_pkg::CH_W-1:0]            color
);

  localparam int CH_W      = sao_pkg::CH_W;
  localparam int PROD_W    = sao_pkg::PROD_W;
  localparam int NUM_W     = sao_pkg::NUM_W;
  localparam int QBITS     = sao_pkg::QBITS;
  localparam int DEPTH     = sao_pkg::DEPTH;
  localparam int DIV_FIRST = sao_pkg::DIV_FIRST;

  logic [CH_W-1:0]        sc0;
  logic [CH_W-1:0]        dc_line [DEPTH-1];
  logic [PROD_W-1:0]      ps1;
  logic [PROD_W-1:0]      pd1;
  logic [PROD_W+CH_W-1:0] pd_inv;
  logic [NUM_W-1:0]       num2;
  logic [NUM_W-1:0]       rem [QBITS-1];
  logic [QBITS-1:0]       quo [QBITS-1];

  assign pd_inv = (PROD_W+CH_W)'(pd1) * (PROD_W+CH_W)'(inv1);

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      sc0        <= sc;
      dc_line[0] <= dc;
    end
    for (int s = 1; s < DEPTH-1; s++) begin
      if (ctrl.en[s]) begin
        dc_line[s] <= dc_line[s-1];
      end
    end
    if (ctrl.en[1]) begin
      ps1 <= PROD_W'(sc0) * PROD_W'(sa0);
      pd1 <= PROD_W'(dc_line[0]) * PROD_W'(da0);
    end
    if (ctrl.en[2]) begin
      // ps1 * 255 as a shift and subtract.
      num2 <= (NUM_W'(ps1) << CH_W) - NUM_W'(ps1) + NUM_W'(pd_inv);
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int SH = QBITS - 1 - j;
    logic [NUM_W-1:0] r_in;
    logic [NUM_W-1:0] dsh;
    logic             ge;

    if (j == 0) begin : g_first
      assign r_in = num2;
    end else begin : g_next
      assign r_in = rem[j-1];
    end

    assign dsh = NUM_W'(cov_line[j]) << SH;
    assign ge  = r_in >= dsh;

    if (j < QBITS-1) begin : g_mid
      logic [QBITS-1:0] q_prev;
      if (j == 0) begin : g_q0
        assign q_prev = '0;
      end else begin : g_qn
        assign q_prev = quo[j-1];
      end
      always_ff @(posedge clk) begin
        if (ctrl.en[DIV_FIRST+j]) begin
          rem[j] <= ge ? r_in - dsh : r_in;
          quo[j] <= {q_prev[QBITS-2:0], ge};
        end
      end
    end else begin : g_last
      // A transparent source passes the destination colour through.
      always_ff @(posedge clk) begin
        if (ctrl.en[DEPTH-1]) begin
          color <= bypass ? dc_line[DEPTH-2] : {quo[j-1][QBITS-2:0], ge};
        end
      end
    end
  end

endmodule

[rtl/straight_alpha_over_blend.sv]
// Top level: straight-alpha source-over blending of one RGBA8 pixel pair per clock.
//
// pix_in carries a source and a destination pixel, both with straight alpha;
// pix_out carries the blended pixel. Both channels transfer on valid and ready.
// Throughput is one pixel per clock while pix_out is not stalled: every stage,
// including each of the eight divider stages that produce one quotient bit
// with one compare and subtract, takes a new pixel at every edge.
// A pixel passes the input, product and numerator stages and then the divider
// stages, the last of which is the output register that drives pix_out.
// Three colour lanes run side by side; coverage and alpha are computed once
// and merged with the lane results in the output register.
// A transparent source (alpha 0) returns the destination pixel unchanged.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// When the receiver stalls, the result holds on pix_out and the stages behind
// it keep filling empty slots; pix_in.ready falls only once every stage is full.
`timescale 1ns / 1ps

module straight_alpha_over_blend (
  input  logic      clk,
  input  logic      rst,
  sao_in_if.sink    pix_in,
  sao_out_if.source pix_out
);

  localparam int CH_W      = sao_pkg::CH_W;
  localparam int COV_W     = sao_pkg::COV_W;
  localparam int QBITS     = sao_pkg::QBITS;
  localparam int LANES     = sao_pkg::LANES;
  localparam int DEPTH     = sao_pkg::DEPTH;
  localparam int DIV_FIRST = sao_pkg::DIV_FIRST;

  sao_pkg::pipe_ctrl_t ctrl;

  logic [CH_W-1:0]  src_c [LANES];
  logic [CH_W-1:0]  dst_c [LANES];
  logic [CH_W-1:0]  lane_color [LANES];

  logic [CH_W-1:0]  sa0;
  logic [CH_W-1:0]  inv1;
  logic [COV_W-1:0] covs1;
  logic [COV_W-1:0] covd1;
  logic [CH_W-1:0]  da_line [DEPTH-1];
  logic             byp_line [1:DEPTH-2];
  logic [COV_W-1:0] cov_line [QBITS];
  logic [CH_W-1:0]  alpha_line [DIV_FIRST:DEPTH-2];
  logic [CH_W-1:0]  alpha_out;
  logic [COV_W:0]   cov_p1;
  logic [COV_W+9:0] alpha_prod;

  assign src_c[0] = pix_in.src_red;
  assign src_c[1] = pix_in.src_green;
  assign src_c[2] = pix_in.src_blue;
  assign dst_c[0] = pix_in.dst_red;
  assign dst_c[1] = pix_in.dst_green;
  assign dst_c[2] = pix_in.dst_blue;

  sao_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .out_ready(pix_out.ready),
    .ctrl     (ctrl)
  );

  assign cov_p1     = (COV_W+1)'(cov_line[0]) + 1'b1;
  assign alpha_prod = (COV_W+10)'(cov_p1) * (COV_W+10)'(sao_pkg::RECIP_255);

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      sa0        <= pix_in.src_alpha;
      da_line[0] <= pix_in.dst_alpha;
    end
    for (int s = 1; s < DEPTH-1; s++) begin
      if (ctrl.en[s]) begin
        da_line[s] <= da_line[s-1];
      end
    end
    if (ctrl.en[1]) begin
      inv1        <= sao_pkg::CH_MAX - sa0;
      covs1       <= (COV_W'(sa0) << CH_W) - COV_W'(sa0);
      covd1       <= COV_W'(da_line[0]) * COV_W'(sao_pkg::CH_MAX - sa0);
      byp_line[1] <= (sa0 == '0);
    end
    for (int s = 2; s < DEPTH-1; s++) begin
      if (ctrl.en[s]) begin
        byp_line[s] <= byp_line[s-1];
      end
    end
    if (ctrl.en[DIV_FIRST-1]) begin
      cov_line[0] <= covs1 + covd1;
    end
    for (int k = 1; k < QBITS; k++) begin
      if (ctrl.en[DIV_FIRST-1+k]) begin
        cov_line[k] <= cov_line[k-1];
      end
    end
    if (ctrl.en[DIV_FIRST]) begin
      alpha_line[DIV_FIRST] <= alpha_prod[COV_W+CH_W-1:COV_W];
    end
    for (int s = DIV_FIRST+1; s < DEPTH-1; s++) begin
      if (ctrl.en[s]) begin
        alpha_line[s] <= alpha_line[s-1];
      end
    end
    if (ctrl.en[DEPTH-1]) begin
      alpha_out <= byp_line[DEPTH-2] ? da_line[DEPTH-2] : alpha_line[DEPTH-2];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sao_lane u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .sc      (src_c[l]),
      .dc      (dst_c[l]),
      .sa0     (sa0),
      .da0     (da_line[0]),
      .inv1    (inv1),
      .cov_line(cov_line),
      .bypass  (byp_line[DEPTH-2]),
      .color   (lane_color[l])
    );
  end

  assign pix_in.ready      = ctrl.en[0];
  assign pix_out.valid     = ctrl.valid[DEPTH-1];
  assign pix_out.out_red   = lane_color[0];
  assign pix_out.out_green = lane_color[1];
  assign pix_out.out_blue  = lane_color[2];
  assign pix_out.out_alpha = alpha_out;

endmodule

[rtl/sao_checker.sv]
// Port-level checks of the blender, bound to the top level.
`timescale 1ns / 1ps

module sao_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // A stalled result holds until it transfers.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha))
    else $error("stalled result changed before transfer");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // With the output slot free or draining, the pipeline always has room.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled although the output can move");

endmodule

bind straight_alpha_over_blend sao_checker u_sao_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (pix_in.ready),
  .out_valid(pix_out.valid),
  .out_ready(pix_out.ready),
  .out_red  (pix_out.out_red),
  .out_green(pix_out.out_green),
  .out_blue (pix_out.out_blue),
  .out_alpha(pix_out.out_alpha)
);
